FILE: rtl/tos_pkg.sv
`default_nettype none
package tos_pkg;

  localparam logic [4:0] CMD_PUSH_INT     = 5'd0;
  localparam logic [4:0] CMD_PUSH_MARK    = 5'd1;
  localparam logic [4:0] CMD_ADD          = 5'd2;
  localparam logic [4:0] CMD_SUB          = 5'd3;
  localparam logic [4:0] CMD_MUL          = 5'd4;
  localparam logic [4:0] CMD_DIV          = 5'd5;
  localparam logic [4:0] CMD_GT           = 5'd6;
  localparam logic [4:0] CMD_GE           = 5'd7;
  localparam logic [4:0] CMD_LT           = 5'd8;
  localparam logic [4:0] CMD_LE           = 5'd9;
  localparam logic [4:0] CMD_EQ           = 5'd10;
  localparam logic [4:0] CMD_NE           = 5'd11;
  localparam logic [4:0] CMD_NOT          = 5'd12;
  localparam logic [4:0] CMD_POP          = 5'd13;
  localparam logic [4:0] CMD_CHOOSE       = 5'd14;
  localparam logic [4:0] CMD_ROT          = 5'd15;
  localparam logic [4:0] CMD_CHECK_PARAMS = 5'd16;
  localparam logic [4:0] CMD_RETURN_N     = 5'd17;
  localparam logic [4:0] CMD_ASSERT_TRUE  = 5'd18;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_NOTINT  = 3'd3;
  localparam logic [2:0] ST_MARKEXP = 3'd4;
  localparam logic [2:0] ST_MARKIN  = 3'd5;
  localparam logic [2:0] ST_DIVZERO = 3'd6;
  localparam logic [2:0] ST_ASSERT  = 3'd7;

  typedef struct packed {
    logic        mark;
    logic [31:0] val;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [4:0]  op;
    logic [31:0] b;
    logic [31:0] a;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/tos_alu.sv
`default_nettype none
module tos_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tos_pkg::alu_req_t req_i,
  output tos_pkg::alu_rsp_t      rsp_o
);
  import tos_pkg::*;

  logic        busy_q;
  logic [4:0]  step_q;
  logic [31:0] quo_q, rem_q, dvs_q;
  logic        neg_q;
  logic        done_q;
  logic [31:0] res_q;

  logic [31:0] abs_a, abs_b, r_shift, quo_nx, rem_nx, fast;
  logic [32:0] trial;

  always_comb begin
    abs_a   = req_i.a[31] ? (32'd0 - req_i.a) : req_i.a;
    abs_b   = req_i.b[31] ? (32'd0 - req_i.b) : req_i.b;
    r_shift = {rem_q[30:0], quo_q[31]};
    trial   = {1'b0, r_shift} - {1'b0, dvs_q};
    if (!trial[32]) begin
      rem_nx = trial[31:0];
      quo_nx = {quo_q[30:0], 1'b1};
    end else begin
      rem_nx = r_shift;
      quo_nx = {quo_q[30:0], 1'b0};
    end
    case (req_i.op)
      CMD_ADD: fast = req_i.b + req_i.a;
      CMD_SUB: fast = req_i.b - req_i.a;
      CMD_MUL: fast = req_i.b * req_i.a;
      CMD_GT:  fast = {31'd0, $signed(req_i.b) >  $signed(req_i.a)};
      CMD_GE:  fast = {31'd0, $signed(req_i.b) >= $signed(req_i.a)};
      CMD_LT:  fast = {31'd0, $signed(req_i.b) <  $signed(req_i.a)};
      CMD_LE:  fast = {31'd0, $signed(req_i.b) <= $signed(req_i.a)};
      default: fast = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.op == CMD_DIV) begin
          busy_q <= 1'b1;
          step_q <= '0;
        end else begin
          done_q <= 1'b1;
        end
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      res_q <= fast;
      quo_q <= abs_b;
      rem_q <= '0;
      dvs_q <= abs_a;
      neg_q <= req_i.a[31] ^ req_i.b[31];
    end else if (busy_q) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
      if (step_q == 5'd31) begin
        res_q <= neg_q ? (32'd0 - quo_nx) : quo_nx;
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule
`default_nettype wire

FILE: rtl/tagged_operand_stack_engine.sv
`default_nettype none
// channel | signals                                   | transfer when
// in      | in_valid_i, in_stall_o, cmd/immediate/depth | in_valid_i & !in_stall_o
// out     | out_valid_o, out_stall_i, status/top/taken/count | out_valid_o & !out_stall_i
// One instruction at a time; in_stall_o is high until the sequencer is idle again.
// Div uses a radix-2 divider in tos_alu.
// rot, check_params, return_n: step through n entries, one stack RAM port each way.
// Reset clears control and count only; stack RAM contents are undefined.
// A result held by out_stall_i blocks completion of the next instruction only.
module tagged_operand_stack_engine #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [4:0]                         cmd_i,
  input  wire logic signed [31:0]                 immediate_i,
  input  wire logic [5:0]                         depth_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [2:0]                              status_o,
  output logic signed [31:0]                      top_value_o,
  output logic                                    taken_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]        entry_count_o
);
  import tos_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int NW = ((CW > 6) ? CW : 6) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_LDA   = 4'd2;
  localparam logic [3:0] S_LDB   = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_ALU   = 4'd5;
  localparam logic [3:0] S_SCRD  = 4'd6;
  localparam logic [3:0] S_SCCK  = 4'd7;
  localparam logic [3:0] S_POST  = 4'd8;
  localparam logic [3:0] S_RETCK = 4'd9;
  localparam logic [3:0] S_MVRD  = 4'd10;
  localparam logic [3:0] S_MVWR  = 4'd11;
  localparam logic [3:0] S_TAIL  = 4'd12;
  localparam logic [3:0] S_TOP   = 4'd13;
  localparam logic [3:0] S_TOPCK = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  localparam entry_t MARK_E = '{mark: 1'b1, val: 32'd0};

  entry_t mem [STACK_DEPTH];
  entry_t rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  logic [3:0]  state_q, state_d;
  logic [4:0]  cmd_q, cmd_d;
  logic [31:0] imm_q, imm_d;
  logic [5:0]  n_q, n_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt0_q, cnt0_d, ptr_q, ptr_d, rem_q, rem_d;
  entry_t      a_q, a_d, b_q, b_d;
  logic [2:0]  st_q, st_d;
  logic        chosen_q, chosen_d, taken_q, taken_d;
  logic [31:0] top_q, top_d;
  logic        ov_q, ov_d;
  logic [2:0]  os_q, os_d;
  logic [31:0] ot_q, ot_d;
  logic        ok_q, ok_d;
  logic [CW-1:0] oc_q, oc_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [CW-1:0] cm1, cm2, nc, base, ptr_src;
  logic [NW-1:0] cw_ext, nw_ext;
  logic          up;

  tos_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    cm1     = cnt_q - CW'(1);
    cm2     = cnt_q - CW'(2);
    nc      = CW'(n_q);
    base    = cm1 - nc;
    cw_ext  = NW'(cnt_q);
    nw_ext  = NW'(n_q);
    up      = (cmd_q == CMD_CHECK_PARAMS);
    ptr_src = up ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));

    state_d  = state_q;
    cmd_d    = cmd_q;
    imm_d    = imm_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    cnt0_d   = cnt0_q;
    ptr_d    = ptr_q;
    rem_d    = rem_q;
    a_d      = a_q;
    b_d      = b_q;
    st_d     = st_q;
    chosen_d = chosen_q;
    taken_d  = taken_q;
    top_d    = top_q;
    ov_d     = ov_q;
    os_d     = os_q;
    ot_d     = ot_q;
    ok_d     = ok_q;
    oc_d     = oc_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = MARK_E;
    mem_raddr = '0;

    alu_req.start = 1'b0;
    alu_req.op    = cmd_q;
    alu_req.b     = b_q.val;
    alu_req.a     = a_q.val;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_i;
          imm_d    = immediate_i;
          n_d      = depth_i;
          cnt0_d   = cnt_q;
          st_d     = ST_OK;
          chosen_d = 1'b0;
          taken_d  = 1'b0;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_TOP;
        case (cmd_q) inside
          CMD_PUSH_INT, CMD_PUSH_MARK: begin
            if (cnt_q == CW'(STACK_DEPTH)) begin
              st_d = ST_OVER;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt_q[AW-1:0];
              mem_wdata = (cmd_q == CMD_PUSH_INT) ? entry_t'{mark: 1'b0, val: imm_q} : MARK_E;
              cnt_d     = cnt_q + CW'(1);
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GT, CMD_GE, CMD_LT, CMD_LE,
          CMD_EQ, CMD_NE: begin
            if (cnt_q < CW'(2)) begin
              st_d = ST_UNDER;
            end else begin
              mem_raddr = cm1[AW-1:0];
              state_d   = S_LDA;
            end
          end
          CMD_NOT, CMD_CHOOSE, CMD_ASSERT_TRUE, CMD_CHECK_PARAMS: begin
            if (cnt_q == '0) begin
              st_d = ST_UNDER;
            end else begin
              mem_raddr = cm1[AW-1:0];
              state_d   = S_LDA;
            end
          end
          CMD_POP: begin
            if (cnt_q == '0) begin
              st_d = ST_UNDER;
            end else begin
              cnt_d = cm1;
            end
          end
          CMD_ROT: begin
            if (n_q != '0) begin
              if (cw_ext <= nw_ext) begin
                st_d = ST_UNDER;
              end else begin
                mem_raddr = base[AW-1:0];
                state_d   = S_LDA;
              end
            end
          end
          CMD_RETURN_N: begin
            if (cw_ext <= nw_ext) begin
              st_d = ST_UNDER;
            end else begin
              ptr_d   = cnt_q - nc;
              rem_d   = nc;
              state_d = (n_q == '0) ? S_POST : S_SCRD;
            end
          end
          default: ;
        endcase
      end
      S_LDA: begin
        a_d = rdata_q;
        case (cmd_q) inside
          CMD_NOT, CMD_CHOOSE, CMD_ASSERT_TRUE: state_d = S_EXEC;
          CMD_CHECK_PARAMS: begin
            if (!rdata_q.mark) begin
              st_d    = ST_MARKEXP;
              state_d = S_TOP;
            end else if (cw_ext <= nw_ext) begin
              st_d    = ST_UNDER;
              state_d = S_TOP;
            end else begin
              ptr_d   = base;
              rem_d   = nc;
              state_d = (n_q == '0) ? S_POST : S_SCRD;
            end
          end
          CMD_ROT: begin
            ptr_d   = base;
            rem_d   = nc;
            state_d = S_MVRD;
          end
          default: begin
            mem_raddr = cm2[AW-1:0];
            state_d   = S_LDB;
          end
        endcase
      end
      S_LDB: begin
        b_d     = rdata_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_TOP;
        case (cmd_q) inside
          CMD_EQ, CMD_NE: begin
            mem_we    = 1'b1;
            mem_waddr = cm2[AW-1:0];
            mem_wdata = '{mark: 1'b0,
                          val: {31'd0, (cmd_q == CMD_EQ) ==
                                       ((a_q.mark && b_q.mark) || (a_q == b_q))}};
            cnt_d     = cm1;
          end
          CMD_NOT, CMD_CHOOSE, CMD_ASSERT_TRUE: begin
            if (a_q.mark) begin
              st_d = ST_NOTINT;
            end else if (cmd_q == CMD_NOT) begin
              mem_we    = 1'b1;
              mem_waddr = cm1[AW-1:0];
              mem_wdata = '{mark: 1'b0, val: {31'd0, a_q.val == 32'd0}};
            end else if (cmd_q == CMD_CHOOSE) begin
              chosen_d = 1'b1;
              taken_d  = (a_q.val != 32'd0);
              top_d    = a_q.val;
              cnt_d    = cm1;
            end else if (a_q.val == 32'd0) begin
              st_d = ST_ASSERT;
            end else begin
              cnt_d = cm1;
            end
          end
          default: begin
            if (a_q.mark || b_q.mark) begin
              st_d = ST_NOTINT;
            end else if (cmd_q == CMD_DIV && a_q.val == 32'd0) begin
              st_d = ST_DIVZERO;
            end else begin
              alu_req.start = 1'b1;
              state_d       = S_ALU;
            end
          end
        endcase
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = cm2[AW-1:0];
          mem_wdata = '{mark: 1'b0, val: alu_rsp.result};
          cnt_d     = cm1;
          state_d   = S_TOP;
        end
      end
      S_SCRD: begin
        mem_raddr = ptr_q[AW-1:0];
        state_d   = S_SCCK;
      end
      S_SCCK: begin
        if (rdata_q.mark) begin
          st_d    = ST_MARKIN;
          state_d = S_TOP;
        end else begin
          ptr_d   = ptr_q + CW'(1);
          rem_d   = rem_q - CW'(1);
          state_d = (rem_q == CW'(1)) ? S_POST : S_SCRD;
        end
      end
      S_POST: begin
        if (up) begin
          ptr_d   = cm1;
          rem_d   = nc;
          state_d = (n_q == '0) ? S_TAIL : S_MVRD;
        end else begin
          mem_raddr = base[AW-1:0];
          state_d   = S_RETCK;
        end
      end
      S_RETCK: begin
        if (!rdata_q.mark) begin
          st_d    = ST_MARKEXP;
          state_d = S_TOP;
        end else begin
          ptr_d   = base;
          rem_d   = nc;
          state_d = (n_q == '0) ? S_TAIL : S_MVRD;
        end
      end
      S_MVRD: begin
        mem_raddr = ptr_src[AW-1:0];
        state_d   = S_MVWR;
      end
      S_MVWR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AW-1:0];
        mem_wdata = rdata_q;
        ptr_d     = ptr_src;
        rem_d     = rem_q - CW'(1);
        state_d   = (rem_q == CW'(1)) ? S_TAIL : S_MVRD;
      end
      S_TAIL: begin
        state_d = S_TOP;
        if (cmd_q == CMD_ROT) begin
          mem_we    = 1'b1;
          mem_waddr = cm1[AW-1:0];
          mem_wdata = a_q;
        end else if (up) begin
          mem_we    = 1'b1;
          mem_waddr = base[AW-1:0];
          mem_wdata = MARK_E;
        end else begin
          cnt_d = cm1;
        end
      end
      S_TOP: begin
        if (chosen_q) begin
          state_d = S_OUT;
        end else if (cnt_q == '0) begin
          top_d   = '0;
          state_d = S_OUT;
        end else begin
          mem_raddr = cm1[AW-1:0];
          state_d   = S_TOPCK;
        end
      end
      S_TOPCK: begin
        top_d   = rdata_q.mark ? 32'd0 : rdata_q.val;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          os_d    = st_q;
          ot_d    = top_q;
          ok_d    = taken_q;
          oc_d    = cnt_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    imm_q    <= imm_d;
    n_q      <= n_d;
    cnt0_q   <= cnt0_d;
    ptr_q    <= ptr_d;
    rem_q    <= rem_d;
    a_q      <= a_d;
    b_q      <= b_d;
    st_q     <= st_d;
    chosen_q <= chosen_d;
    taken_q  <= taken_d;
    top_q    <= top_d;
    os_q     <= os_d;
    ot_q     <= ot_d;
    ok_q     <= ok_d;
    oc_q     <= oc_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = ov_q;
  assign status_o      = os_q;
  assign top_value_o   = ot_q;
  assign taken_o       = ok_q;
  assign entry_count_o = oc_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond capacity");

  a_fault_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && st_q != ST_OK) |-> cnt_q == cnt0_q)
    else $error("faulting instruction changed the stack count");

  a_alu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_ALU)
    else $error("alu result outside of wait state");

endmodule
`default_nettype wire
